// ===== hw/rtl/hrsp_pkg.sv =====
`default_nettype none

package hrsp_pkg;

    // Characters the matchers look for
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_C = 8'h43;

    // "Content-Length:" is fifteen characters long
    localparam logic [3:0] TAG_LEN = 4'd15;

    localparam logic [9:0]  STATUS_OK_CODE = 10'd200;
    localparam logic [9:0]  STATUS_MAX     = 10'd999;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

    // One result item as it leaves the parser core
    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        header_done;
        logic        content_done;
        logic [31:0] content_length;
        logic [9:0]  status_code;
        logic        status_ok;
    } result_t;

    // Character of the length tag at a given position
    function automatic logic [7:0] tag_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/http_response_stream_parser.sv =====
// Throughput: one item per cycle while the skid register is empty; the parse state
// updates in the accept cycle, and the result is registered in the result or skid register.
// A two-entry output stage (result register plus skid register) keeps input
// accepted for one more item while a result waits on m_tready.
// Reset: aresetn is synchronous, active low; it clears all parse state and empties the output.
`default_nettype none

module http_response_stream_parser #(
    parameter int MAX_DIGITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] restart
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata,   // [7:0] body_byte, [8] header_done,
                                        // [9] content_done, [41:10] content_length,
                                        // [51:42] status_code, [52] status_ok, [55:53] zero
    output      logic [0:0]  m_tuser    // [0] body_valid
);

    hrsp_pkg::result_t core_result;
    hrsp_pkg::result_t out_reg;
    hrsp_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              in_accept;
    logic              out_free;
    logic              load_out;
    logic              load_skid;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign load_out  = out_free && (skid_valid_reg || in_accept);
    assign load_skid = !out_free && in_accept;

    hrsp_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .in_restart (s_tuser[0]),
        .result     (core_result)
    );

    // Track which output entries hold an item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg  <= skid_valid_reg || in_accept;
                skid_valid_reg <= 1'b0;
            end else if (in_accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Move result payloads
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= skid_valid_reg ? skid_reg : core_result;
        end
        if (load_skid) begin
            skid_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.body_valid;
    assign m_tdata  = {3'd0, out_reg.status_ok, out_reg.status_code, out_reg.content_length,
                       out_reg.content_done, out_reg.header_done, out_reg.body_byte};

    // Skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    // Body bytes only appear once the header is done
    a_body_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tdata[8])
        else $error("body byte flagged before header end");

    // Content cannot finish before the header
    a_content_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> m_tdata[8])
        else $error("content done without header done");

    // Status ok agrees with the reported code
    a_status_ok_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[52]) |-> (m_tdata[51:42] == hrsp_pkg::STATUS_OK_CODE))
        else $error("status ok set with a code other than 200");

endmodule

`default_nettype wire

// ===== hw/rtl/hrsp_core.sv =====
`default_nettype none

module hrsp_core #(
    parameter int MAX_DIGITS = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_accept,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_restart,
    output hrsp_pkg::result_t    result
);

    localparam int DigitW = $clog2(MAX_DIGITS + 1);
    localparam logic [DigitW-1:0] DigitLimit = DigitW'(MAX_DIGITS);

    // Content-Length value phases
    localparam logic [1:0] LEN_TAG    = 2'd0;
    localparam logic [1:0] LEN_VALUE  = 2'd1;
    localparam logic [1:0] LEN_CLOSED = 2'd2;

    // Status code phases
    localparam logic [1:0] ST_WAIT_SPACE = 2'd0;
    localparam logic [1:0] ST_DIGITS     = 2'd1;
    localparam logic [1:0] ST_CLOSED     = 2'd2;

    logic [1:0]        term_match_reg,   term_match_next;
    logic              header_seen_reg,  header_seen_next;
    logic              content_seen_reg, content_seen_next;
    logic [3:0]        tag_match_reg,    tag_match_next;
    logic [1:0]        len_phase_reg,    len_phase_next;
    logic              prev_cr_reg,      prev_cr_next;
    logic [DigitW-1:0] digit_count_reg,  digit_count_next;
    logic [31:0]       len_value_reg,    len_value_next;
    logic [1:0]        st_phase_reg,     st_phase_next;
    logic [9:0]        st_value_reg,     st_value_next;
    logic [31:0]       body_count_reg,   body_count_next;

    logic        is_digit;
    logic [3:0]  digit_val;
    logic [35:0] len_prod;
    logic [13:0] st_prod;
    logic [3:0]  tag_step;
    logic        body;

    assign is_digit  = (in_byte >= hrsp_pkg::CHAR_ZERO) && (in_byte <= hrsp_pkg::CHAR_NINE);
    assign digit_val = in_byte[3:0];

    // Times ten as two shifts and an add
    assign len_prod = ({4'd0, len_value_reg} << 3) + ({4'd0, len_value_reg} << 1)
                    + {32'd0, digit_val};
    assign st_prod  = ({4'd0, st_value_reg} << 3) + ({4'd0, st_value_reg} << 1)
                    + {10'd0, digit_val};

    // Update parse state for one item
    always_comb begin
        term_match_next   = term_match_reg;
        header_seen_next  = header_seen_reg;
        content_seen_next = content_seen_reg;
        tag_match_next    = tag_match_reg;
        len_phase_next    = len_phase_reg;
        prev_cr_next      = prev_cr_reg;
        digit_count_next  = digit_count_reg;
        len_value_next    = len_value_reg;
        st_phase_next     = st_phase_reg;
        st_value_next     = st_value_reg;
        body_count_next   = body_count_reg;
        tag_step          = 4'd0;
        body              = 1'b0;

        if (in_restart) begin
            term_match_next   = 2'd0;
            header_seen_next  = 1'b0;
            content_seen_next = 1'b0;
            tag_match_next    = 4'd0;
            len_phase_next    = LEN_TAG;
            prev_cr_next      = 1'b0;
            digit_count_next  = '0;
            len_value_next    = 32'd0;
            st_phase_next     = ST_WAIT_SPACE;
            st_value_next     = 10'd0;
            body_count_next   = 32'd0;
        end else if (!header_seen_reg) begin
            // Content-Length tag and value
            if (len_phase_reg == LEN_VALUE) begin
                if (in_byte == hrsp_pkg::CHAR_LF && prev_cr_reg) begin
                    len_phase_next = LEN_CLOSED;
                end else if (is_digit && digit_count_reg < DigitLimit) begin
                    len_value_next   = (len_prod[35:32] != 4'd0) ? hrsp_pkg::COUNT_MAX
                                                                 : len_prod[31:0];
                    digit_count_next = digit_count_reg + DigitW'(1);
                end
                prev_cr_next = (in_byte == hrsp_pkg::CHAR_CR);
            end else if (len_phase_reg == LEN_TAG) begin
                if (in_byte == hrsp_pkg::tag_char(tag_match_reg)) begin
                    tag_step = tag_match_reg + 4'd1;
                end else begin
                    tag_step = (in_byte == hrsp_pkg::CHAR_UPPER_C) ? 4'd1 : 4'd0;
                end
                if (tag_step == hrsp_pkg::TAG_LEN) begin
                    len_phase_next = LEN_VALUE;
                    tag_match_next = 4'd0;
                    prev_cr_next   = 1'b0;
                end else begin
                    tag_match_next = tag_step;
                end
            end

            // Status code after the first space
            if (st_phase_reg == ST_WAIT_SPACE) begin
                if (in_byte == hrsp_pkg::CHAR_SPACE) st_phase_next = ST_DIGITS;
            end else if (st_phase_reg == ST_DIGITS) begin
                if (is_digit) begin
                    st_value_next = (st_prod > {4'd0, hrsp_pkg::STATUS_MAX})
                                  ? hrsp_pkg::STATUS_MAX : st_prod[9:0];
                end else begin
                    st_phase_next = ST_CLOSED;
                end
            end

            // Header terminator CR LF CR LF
            if (!term_match_reg[0] && in_byte == hrsp_pkg::CHAR_CR) begin
                term_match_next = term_match_reg + 2'd1;
            end else if (term_match_reg[0] && in_byte == hrsp_pkg::CHAR_LF) begin
                if (term_match_reg == 2'd3) begin
                    header_seen_next = 1'b1;
                    term_match_next  = 2'd0;
                    if (body_count_reg >= len_value_next) content_seen_next = 1'b1;
                end else begin
                    term_match_next = term_match_reg + 2'd1;
                end
            end else begin
                term_match_next = (in_byte == hrsp_pkg::CHAR_CR) ? 2'd1 : 2'd0;
            end
        end else begin
            // Count body bytes, saturating
            body = 1'b1;
            if (body_count_reg != hrsp_pkg::COUNT_MAX) begin
                body_count_next = body_count_reg + 32'd1;
            end
            if (body_count_next >= len_value_reg) content_seen_next = 1'b1;
        end
    end

    // Build the result from the updated state
    always_comb begin
        result.body_valid     = body;
        result.body_byte      = body ? in_byte : 8'd0;
        result.header_done    = header_seen_next;
        result.content_done   = content_seen_next;
        result.content_length = header_seen_next ? len_value_next : 32'd0;
        result.status_code    = header_seen_next ? st_value_next : 10'd0;
        result.status_ok      = header_seen_next && (st_value_next == hrsp_pkg::STATUS_OK_CODE);
    end

    // Advance state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_match_reg   <= 2'd0;
            header_seen_reg  <= 1'b0;
            content_seen_reg <= 1'b0;
            tag_match_reg    <= 4'd0;
            len_phase_reg    <= LEN_TAG;
            prev_cr_reg      <= 1'b0;
            digit_count_reg  <= '0;
            len_value_reg    <= 32'd0;
            st_phase_reg     <= ST_WAIT_SPACE;
            st_value_reg     <= 10'd0;
            body_count_reg   <= 32'd0;
        end else if (in_accept) begin
            term_match_reg   <= term_match_next;
            header_seen_reg  <= header_seen_next;
            content_seen_reg <= content_seen_next;
            tag_match_reg    <= tag_match_next;
            len_phase_reg    <= len_phase_next;
            prev_cr_reg      <= prev_cr_next;
            digit_count_reg  <= digit_count_next;
            len_value_reg    <= len_value_next;
            st_phase_reg     <= st_phase_next;
            st_value_reg     <= st_value_next;
            body_count_reg   <= body_count_next;
        end
    end

endmodule

`default_nettype wire
